>>> hdl/lba_pkg.sv
// Shared constants, types and tables for the linkage bucket angle block.
// Used by every module under hdl/; has no dependencies of its own.
package lba_pkg;

	localparam int ANGLE_FRAC_BITS = 13;
	localparam int LENGTH_BITS     = 16;
	localparam int ANG_W           = 17;
	localparam int OUT_W           = 18;
	localparam int Q_SHIFT         = 30 - ANGLE_FRAC_BITS;

	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = PI_Q30 >> 1;
	localparam logic [30:0] Q30_ONE     = 31'd1 << 30;
	localparam logic [32:0] PI_RND      = {1'b0, PI_Q30} + (33'd1 << (Q_SHIFT - 1));
	localparam logic signed [18:0] PI_ANG = signed'(19'(PI_RND >> Q_SHIFT));

	localparam logic signed [19:0] RES_MAX = 20'sd131071;
	localparam logic signed [19:0] RES_MIN = -20'sd131072;

	localparam int COS_TERMS  = 10;
	localparam int COS_LAT    = 3 * COS_TERMS + 3;
	localparam int SQRT_STEPS = 23;
	localparam int DIV_STEPS  = 30;
	localparam int ACOS_STEPS = 32;

	// Taylor divisors (2k-1)(2k) and floor(2^33 / divisor)
	localparam logic [8:0] COS_DIV [COS_TERMS] = '{
		9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380
	};
	localparam logic [32:0] COS_RECIP [COS_TERMS] = '{
		33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689, 33'd95443717,
		33'd65075262, 33'd47197442, 33'd35791394, 33'd28071681, 33'd22605091
	};

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef enum logic [1:0] {
		REG_STICK   = 2'd0,
		REG_BUCKET  = 2'd1,
		REG_LINK    = 2'd2,
		REG_DOGBONE = 2'd3
	} reg_index_t;

	// advance enable and valid of the request entering a pipeline
	typedef struct packed {
		logic adv;
		logic vld;
	} pipe_ctl_t;

endpackage

>>> hdl/linkage_bucket_angle.sv
// Four-bar linkage bucket angle: top level, front end, ratio setup and output stage.
// Depends on lba_pkg, lba_cos, lba_isqrt, lba_div and lba_acos_cell.
// Accepts one request per cycle while in_stall is low.
// The 32 bisection cells, each a 33-stage cosine plus a select stage, set the latency.
// A two-entry output stage (output register and skid) stalls the input only when both are full.
// arst_n clears all valid bits and the output stage; side lengths reset to 1000.
module linkage_bucket_angle
	import lba_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [1:0]              cfg_index,
	input  logic [LENGTH_BITS-1:0]  cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [ANG_W-1:0] stick_angle,
	input  logic signed [ANG_W-1:0] dogbone_angle,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] bucket_angle,
	output logic                    status
);

	len_t ab_q, bc_q, cd_q, ad_q;

	logic                    adv;

	logic signed [18:0]      bad, bad_abs;
	logic                    bad_err;
	logic                    vld_s1, err_s1;
	logic signed [ANG_W-1:0] stick_s1;
	logic [31:0]             mag_s1;

	logic                    cos_vld;
	logic signed [31:0]      cbad;
	logic [ANG_W:0]          cos_side;

	logic                    vld_s2, cneg_s2;
	logic [31:0]             p_s2;
	logic [32:0]             sq_s2;
	logic [30:0]             cabs_s2;
	logic [ANG_W:0]          side_s2;
	logic                    vld_s3, cneg_s3;
	logic [31:0]             t_s3;
	logic [32:0]             sq_s3;
	logic [ANG_W:0]          side_s3;
	logic                    vld_s4;
	logic [34:0]             dsq_s4;
	logic [ANG_W:0]          side_s4;

	logic                    sq_vld;
	logic [SQRT_STEPS-1:0]   bdq;
	logic [33:0]             sq_dsq;
	logic [ANG_W:0]          sq_side;

	logic                    vld_s5;
	logic [38:0]             pab_s5, pbc_s5;
	logic [31:0]             ab2_s5, ad2_s5, bc2_s5, cd2_s5;
	logic [33:0]             dsq_s5;
	logic [ANG_W:0]          side_s5;

	logic signed [36:0]      num [2];
	logic [36:0]             num_abs [2];
	logic [39:0]             den [2];
	logic [41:0]             rsh [2];
	logic [1:0]              ratio_err;
	logic                    vld_s6, err_s6;
	logic [1:0][39:0]        rem_s6, den_s6;
	logic [1:0]              neg_s6;
	logic signed [ANG_W-1:0] stick_s6;

	logic                    div_vld;
	logic [1:0][DIV_STEPS-1:0] quot;
	logic [ANG_W+2:0]        div_side;
	logic [1:0]              div_neg;
	logic [ANG_W:0]          div_keep;
	logic [1:0][31:0]        c_start;

	logic [ACOS_STEPS:0]     a_vld;
	logic [1:0][31:0]        a_lo [ACOS_STEPS+1];
	logic [1:0][31:0]        a_hi [ACOS_STEPS+1];
	logic [1:0][31:0]        a_c  [ACOS_STEPS+1];
	logic [ANG_W:0]          a_side [ACOS_STEPS+1];

	logic [32:0]             acos_sum, acos_rnd;
	logic signed [ANG_W-1:0] stick_f;
	logic                    err_f;
	logic signed [19:0]      res_raw, res_sat;
	logic signed [OUT_W-1:0] bucket_f;

	logic                    out_vld_q, skid_vld_q;
	logic signed [OUT_W-1:0] out_bucket_q, skid_bucket_q;
	logic                    out_status_q, skid_status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_q <= len_t'(1000);
			bc_q <= len_t'(1000);
			cd_q <= len_t'(1000);
			ad_q <= len_t'(1000);
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_STICK:   ab_q <= cfg_data;
				REG_BUCKET:  bc_q <= cfg_data;
				REG_LINK:    cd_q <= cfg_data;
				REG_DOGBONE: ad_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole pipeline moves unless the skid entry is occupied
	assign adv      = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// angle BAD and its range check
	always_comb begin
		bad     = PI_ANG - 19'(dogbone_angle) + 19'(stick_angle);
		bad_abs = (bad < 0) ? -bad : bad;
		bad_err = (bad > PI_ANG) || (bad < -PI_ANG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= cos_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stick_s1 <= stick_angle;
			err_s1   <= bad_err;
			mag_s1   <= 32'(unsigned'(bad_abs)) << Q_SHIFT;
		end
	end

	lba_cos #(.SW(ANG_W + 1)) u_cos_bad (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{adv: adv, vld: vld_s1}),
		.angle    (mag_s1),
		.side_in  ({stick_s1, err_s1}),
		.out_valid(cos_vld),
		.cos_val  (cbad),
		.side_out (cos_side)
	);

	// BD^2 = AB^2 + AD^2 - 2*AB*AD*cos(BAD)
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2    <= 32'(ab_q) * 32'(ad_q);
			sq_s2   <= 33'(ab_q) * 33'(ab_q) + 33'(ad_q) * 33'(ad_q);
			cabs_s2 <= 31'((cbad < 0) ? -cbad : cbad);
			cneg_s2 <= cbad < 0;
			side_s2 <= cos_side;
			t_s3    <= 32'((63'(p_s2) * 63'(cabs_s2)) >> 30);
			sq_s3   <= sq_s2;
			cneg_s3 <= cneg_s2;
			side_s3 <= side_s2;
			dsq_s4  <= cneg_s3 ? 35'(sq_s3) + (35'(t_s3) << 1) : 35'(sq_s3) - (35'(t_s3) << 1);
			side_s4 <= side_s3;
		end
	end

	lba_isqrt #(.SW(34 + ANG_W + 1)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{adv: adv, vld: vld_s4}),
		.radicand ({dsq_s4[33:0], 12'd0}),
		.side_in  ({dsq_s4[33:0], side_s4}),
		.out_valid(sq_vld),
		.root     (bdq),
		.side_out ({sq_dsq, sq_side})
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pab_s5  <= 39'(ab_q) * 39'(bdq);
			pbc_s5  <= 39'(bc_q) * 39'(bdq);
			ab2_s5  <= 32'(ab_q) * 32'(ab_q);
			ad2_s5  <= 32'(ad_q) * 32'(ad_q);
			bc2_s5  <= 32'(bc_q) * 32'(bc_q);
			cd2_s5  <= 32'(cd_q) * 32'(cd_q);
			dsq_s5  <= sq_dsq;
			side_s5 <= sq_side;
		end
	end

	// ratio numerators and denominators; ratio must be strictly inside (-1, 1)
	always_comb begin
		num[0] = signed'(37'(dsq_s5)) + signed'(37'(ab2_s5)) - signed'(37'(ad2_s5));
		num[1] = signed'(37'(dsq_s5)) + signed'(37'(bc2_s5)) - signed'(37'(cd2_s5));
		den[0] = {pab_s5, 1'b0};
		den[1] = {pbc_s5, 1'b0};
		for (int l = 0; l < 2; l++) begin
			num_abs[l]   = unsigned'((num[l] < 0) ? -num[l] : num[l]);
			rsh[l]       = 42'(num_abs[l]) << 6;
			ratio_err[l] = (den[l] == '0) || (rsh[l] >= 42'(den[l]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				rem_s6[l] <= 40'(rsh[l]);
				den_s6[l] <= den[l];
				neg_s6[l] <= num[l] < 0;
			end
			err_s6   <= side_s5[0] | ratio_err[0] | ratio_err[1];
			stick_s6 <= side_s5[ANG_W:1];
		end
	end

	lba_div #(.SW(ANG_W + 3)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{adv: adv, vld: vld_s6}),
		.rem_in   (rem_s6),
		.den_in   (den_s6),
		.side_in  ({neg_s6, stick_s6, err_s6}),
		.out_valid(div_vld),
		.quot     (quot),
		.side_out (div_side)
	);

	assign {div_neg, div_keep} = div_side;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			c_start[l] = div_neg[l] ? -32'(quot[l]) : 32'(quot[l]);
		end
	end

	assign a_vld[0]  = div_vld;
	assign a_lo[0]   = '{default: 32'd0};
	assign a_hi[0]   = '{default: PI_Q30};
	assign a_c[0]    = c_start;
	assign a_side[0] = div_keep;

	for (genvar k = 0; k < ACOS_STEPS; k++) begin : g_acos
		lba_acos_cell #(.SW(ANG_W + 1)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      ('{adv: adv, vld: a_vld[k]}),
			.lo_in    (a_lo[k]),
			.hi_in    (a_hi[k]),
			.c_in     (a_c[k]),
			.side_in  (a_side[k]),
			.out_valid(a_vld[k+1]),
			.lo_out   (a_lo[k+1]),
			.hi_out   (a_hi[k+1]),
			.c_out    (a_c[k+1]),
			.side_out (a_side[k+1])
		);
	end

	// sum of both angles, rounded to angle units, plus stick angle; saturated, and zero on error
	always_comb begin
		{stick_f, err_f} = a_side[ACOS_STEPS];
		acos_sum = 33'(a_lo[ACOS_STEPS][0]) + 33'(a_lo[ACOS_STEPS][1]);
		acos_rnd = (acos_sum + (33'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
		res_raw  = signed'(20'(acos_rnd)) + 20'(stick_f);
		res_sat  = res_raw;
		if (res_raw > RES_MAX) begin
			res_sat = RES_MAX;
		end else if (res_raw < RES_MIN) begin
			res_sat = RES_MIN;
		end
		bucket_f = err_f ? '0 : OUT_W'(res_sat);
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= a_vld[ACOS_STEPS];
			end
		end else if (adv && a_vld[ACOS_STEPS]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_bucket_q <= skid_bucket_q;
				out_status_q <= skid_status_q;
			end else begin
				out_bucket_q <= bucket_f;
				out_status_q <= err_f;
			end
		end else if (adv) begin
			skid_bucket_q <= bucket_f;
			skid_status_q <= err_f;
		end
	end

	assign out_valid    = out_vld_q;
	assign bucket_angle = out_bucket_q;
	assign status       = out_status_q;

endmodule

>>> hdl/lba_cos.sv
// Pipelined Q30 cosine on [0, pi]: one cell of three stages per Taylor term.
// Depends on lba_pkg. The sideband is delayed alongside the cosine.
module lba_cos
	import lba_pkg::*;
#(
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pipe_ctl_t          ctl,
	input  logic [31:0]        angle,
	input  logic [SW-1:0]      side_in,
	output logic               out_valid,
	output logic signed [31:0] cos_val,
	output logic [SW-1:0]      side_out
);

	typedef struct packed {
		logic [31:0]        x2;
		logic               neg;
		logic signed [34:0] sum;
		logic [SW-1:0]      side;
	} carry_t;

	logic [31:0]        a_clip;
	logic               neg_in;
	logic [31:0]        x_full;
	logic               vld_s1;
	logic [30:0]        x_s1;
	logic               neg_s1;
	logic [SW-1:0]      side_s1;
	logic               vld_s2;
	carry_t             car_s2;
	logic [COS_TERMS:0] t_vld;
	logic [COS_TERMS:0][30:0] t_term;
	carry_t             t_car [COS_TERMS+1];
	logic signed [34:0] sum_clip;
	logic               out_vld_q;
	logic signed [31:0] cos_q;
	logic [SW-1:0]      side_q;

	always_comb begin
		a_clip = (angle > PI_Q30) ? PI_Q30 : angle;
		neg_in = a_clip > HALF_PI_Q30;
		x_full = neg_in ? PI_Q30 - a_clip : a_clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1    <= ctl.vld;
			vld_s2    <= vld_s1;
			out_vld_q <= t_vld[COS_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			x_s1        <= 31'(x_full);
			neg_s1      <= neg_in;
			side_s1     <= side_in;
			car_s2.x2   <= 32'((62'(x_s1) * 62'(x_s1)) >> 30);
			car_s2.neg  <= neg_s1;
			car_s2.sum  <= signed'(35'(Q30_ONE));
			car_s2.side <= side_s1;
			cos_q       <= t_car[COS_TERMS].neg ? -32'(sum_clip) : 32'(sum_clip);
			side_q      <= t_car[COS_TERMS].side;
		end
	end

	assign t_vld[0]  = vld_s2;
	assign t_term[0] = Q30_ONE;
	assign t_car[0]  = car_s2;

	for (genvar k = 0; k < COS_TERMS; k++) begin : g_term
		logic        vld_a, vld_b, vld_c;
		logic [32:0] v_a, v_b, q_b, q_fix;
		logic [41:0] rem;
		logic [30:0] term_c;
		carry_t      car_a, car_b, car_c, car_next;

		// reciprocal estimate is low by at most one
		always_comb begin
			rem      = 42'(v_b) - 42'(q_b) * 42'(COS_DIV[k]);
			q_fix    = (rem >= 42'(COS_DIV[k])) ? q_b + 33'd1 : q_b;
			car_next = car_b;
			if (k % 2 == 0) begin
				car_next.sum = car_b.sum - signed'(35'(q_fix));
			end else begin
				car_next.sum = car_b.sum + signed'(35'(q_fix));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a <= 1'b0;
				vld_b <= 1'b0;
				vld_c <= 1'b0;
			end else if (ctl.adv) begin
				vld_a <= t_vld[k];
				vld_b <= vld_a;
				vld_c <= vld_b;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				v_a    <= 33'((63'(t_term[k]) * 63'(t_car[k].x2)) >> 30);
				car_a  <= t_car[k];
				v_b    <= v_a;
				q_b    <= 33'((66'(v_a) * 66'(COS_RECIP[k])) >> 33);
				car_b  <= car_a;
				term_c <= 31'(q_fix);
				car_c  <= car_next;
			end
		end

		assign t_vld[k+1]  = vld_c;
		assign t_term[k+1] = term_c;
		assign t_car[k+1]  = car_c;
	end

	always_comb begin
		sum_clip = t_car[COS_TERMS].sum;
		if (sum_clip < 0) begin
			sum_clip = '0;
		end else if (sum_clip > signed'(35'(Q30_ONE))) begin
			sum_clip = signed'(35'(Q30_ONE));
		end
	end

	assign out_valid = out_vld_q;
	assign cos_val   = cos_q;
	assign side_out  = side_q;

endmodule

>>> hdl/lba_acos_cell.sv
// One bisection step of two arccosines in parallel, each lane with its own cosine.
// Depends on lba_pkg and lba_cos. The cosine results feed a registered select stage.
module lba_acos_cell
	import lba_pkg::*;
#(
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pipe_ctl_t       ctl,
	input  logic [1:0][31:0] lo_in,
	input  logic [1:0][31:0] hi_in,
	input  logic [1:0][31:0] c_in,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [1:0][31:0] lo_out,
	output logic [1:0][31:0] hi_out,
	output logic [1:0][31:0] c_out,
	output logic [SW-1:0]   side_out
);

	logic [1:0][31:0]   mid;
	logic [1:0]         cv;
	logic signed [31:0] cos0, cos1;
	logic [127+SW:0]    ls0;
	logic [127:0]       ls1;
	logic [1:0][31:0]   lo_d, hi_d, mid_d, c_d;
	logic [SW-1:0]      side_d;
	logic               vld_q;
	logic [1:0][31:0]   lo_q, hi_q, c_q;
	logic [SW-1:0]      side_q;
	logic [1:0]         above;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mid[l] = 32'((33'(lo_in[l]) + 33'(hi_in[l])) >> 1);
		end
	end

	lba_cos #(.SW(128 + SW)) u_cos0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.angle    (mid[0]),
		.side_in  ({lo_in[0], hi_in[0], mid[0], c_in[0], side_in}),
		.out_valid(cv[0]),
		.cos_val  (cos0),
		.side_out (ls0)
	);

	lba_cos #(.SW(128)) u_cos1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.angle    (mid[1]),
		.side_in  ({lo_in[1], hi_in[1], mid[1], c_in[1]}),
		.out_valid(cv[1]),
		.cos_val  (cos1),
		.side_out (ls1)
	);

	assign {lo_d[0], hi_d[0], mid_d[0], c_d[0], side_d} = ls0;
	assign {lo_d[1], hi_d[1], mid_d[1], c_d[1]}         = ls1;

	// cos(mid) > c: the angle lies above mid
	assign above[0] = cos0 > signed'(c_d[0]);
	assign above[1] = cos1 > signed'(c_d[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.adv) begin
			vld_q <= cv[0] & cv[1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int l = 0; l < 2; l++) begin
				lo_q[l] <= above[l] ? mid_d[l] : lo_d[l];
				hi_q[l] <= above[l] ? hi_d[l] : mid_d[l];
				c_q[l]  <= c_d[l];
			end
			side_q <= side_d;
		end
	end

	assign out_valid = vld_q;
	assign lo_out    = lo_q;
	assign hi_out    = hi_q;
	assign c_out     = c_q;
	assign side_out  = side_q;

endmodule

>>> hdl/lba_isqrt.sv
// Pipelined floor square root, one result bit per cell.
// Depends on lba_pkg.
module lba_isqrt
	import lba_pkg::*;
#(
	parameter int SW = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_ctl_t               ctl,
	input  logic [2*SQRT_STEPS-1:0] radicand,
	input  logic [SW-1:0]           side_in,
	output logic                    out_valid,
	output logic [SQRT_STEPS-1:0]   root,
	output logic [SW-1:0]           side_out
);

	localparam int VW = 2 * SQRT_STEPS + 1;

	logic [SQRT_STEPS:0]     s_vld;
	logic [SQRT_STEPS:0][VW-1:0] s_rem;
	logic [SQRT_STEPS:0][VW-1:0] s_res;
	logic [SQRT_STEPS:0][SW-1:0] s_side;

	assign s_vld[0]  = ctl.vld;
	assign s_rem[0]  = VW'(radicand);
	assign s_res[0]  = '0;
	assign s_side[0] = side_in;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [VW-1:0] BIT = VW'(1) << (VW - 3 - 2 * i);
		logic [VW-1:0] trial;
		logic          take;
		logic          vld_q;
		logic [VW-1:0] rem_q, res_q;
		logic [SW-1:0] side_q;

		assign trial = s_res[i] + BIT;
		assign take  = s_rem[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (ctl.adv) begin
				vld_q <= s_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_q  <= take ? s_rem[i] - trial : s_rem[i];
				res_q  <= take ? (s_res[i] >> 1) + BIT : s_res[i] >> 1;
				side_q <= s_side[i];
			end
		end

		assign s_vld[i+1]  = vld_q;
		assign s_rem[i+1]  = rem_q;
		assign s_res[i+1]  = res_q;
		assign s_side[i+1] = side_q;
	end

	assign out_valid = s_vld[SQRT_STEPS];
	assign root      = SQRT_STEPS'(s_res[SQRT_STEPS]);
	assign side_out  = s_side[SQRT_STEPS];

endmodule

>>> hdl/lba_div.sv
// Two-lane restoring divider for the cosine ratios, one quotient bit per cell.
// Depends on lba_pkg. Needs rem_in < den_in.
module lba_div
	import lba_pkg::*;
#(
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pipe_ctl_t        ctl,
	input  logic [1:0][39:0] rem_in,
	input  logic [1:0][39:0] den_in,
	input  logic [SW-1:0]    side_in,
	output logic             out_valid,
	output logic [1:0][DIV_STEPS-1:0] quot,
	output logic [SW-1:0]    side_out
);

	logic [DIV_STEPS:0]                    s_vld;
	logic [DIV_STEPS:0][1:0][39:0]         s_rem;
	logic [DIV_STEPS:0][1:0][39:0]         s_den;
	logic [DIV_STEPS:0][1:0][DIV_STEPS-1:0] s_q;
	logic [DIV_STEPS:0][SW-1:0]            s_side;

	assign s_vld[0]  = ctl.vld;
	assign s_rem[0]  = rem_in;
	assign s_den[0]  = den_in;
	assign s_q[0]    = '0;
	assign s_side[0] = side_in;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [1:0][40:0]          r2;
		logic [1:0]                take;
		logic                      vld_q;
		logic [1:0][39:0]          rem_q, den_q;
		logic [1:0][DIV_STEPS-1:0] q_q;
		logic [SW-1:0]             side_q;

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l]   = {s_rem[i][l], 1'b0};
				take[l] = r2[l] >= {1'b0, s_den[i][l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else if (ctl.adv) begin
				vld_q <= s_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				for (int l = 0; l < 2; l++) begin
					rem_q[l] <= take[l] ? 40'(r2[l] - {1'b0, s_den[i][l]}) : 40'(r2[l]);
					q_q[l]   <= {s_q[i][l][DIV_STEPS-2:0], take[l]};
				end
				den_q  <= s_den[i];
				side_q <= s_side[i];
			end
		end

		assign s_vld[i+1]  = vld_q;
		assign s_rem[i+1]  = rem_q;
		assign s_den[i+1]  = den_q;
		assign s_q[i+1]    = q_q;
		assign s_side[i+1] = side_q;
	end

	assign out_valid = s_vld[DIV_STEPS];
	assign quot      = s_q[DIV_STEPS];
	assign side_out  = s_side[DIV_STEPS];

endmodule

>>> hdl/lba_checker.sv
// Port-level checks for linkage_bucket_angle, attached by the bind below.
// Depends on lba_pkg for the output width.
module lba_checker
	import lba_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] bucket_angle,
	input logic                    status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result request dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> bucket_angle == '0)
		else $error("bucket angle not zero on impossible geometry");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with output register empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall raised without a held result");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input stall held after output drained");

endmodule

bind linkage_bucket_angle lba_checker u_lba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bucket_angle(bucket_angle),
	.status      (status)
);
